[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// No dependencies; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_HOLD(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("checker: property failed");

// Antecedent in one cycle implies the consequent in the next.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("checker: next-cycle property failed");

`endif

[rtl/i2p_pkg.sv]
// Shared types, constants and functions of the infix-to-postfix converter.
// No dependencies.
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5,
    OP_POW  = 3'd6
  } op_code_t;

  // Command broadcast to every stack cell.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [2:0] code;
  } stack_cmd_t;

  function automatic logic [1:0] op_prec(input logic [2:0] c);
    case (c)
      OP_ADD, OP_SUB:         op_prec = 2'd1;
      OP_MUL, OP_DIV, OP_MOD: op_prec = 2'd2;
      OP_POW:                 op_prec = 2'd3;
      default:                op_prec = 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] op_char(input logic [2:0] c);
    case (c)
      OP_ADD:  op_char = CH_ADD;
      OP_SUB:  op_char = CH_SUB;
      OP_MUL:  op_char = CH_MUL;
      OP_DIV:  op_char = CH_DIV;
      OP_MOD:  op_char = CH_MOD;
      OP_POW:  op_char = CH_POW;
      default: op_char = CH_OPEN;
    endcase
  endfunction

endpackage

[rtl/i2p_cell.sv]
// One stack cell: holds a 3-bit operator code and shifts with its neighbors.
// Depends on i2p_pkg.
module i2p_cell
  import i2p_pkg::*;
(
  input  logic       clk,
  input  stack_cmd_t cmd,
  input  logic [2:0] above,
  input  logic [2:0] below,
  output logic [2:0] code
);

  // Push shifts toward the bottom, pop shifts toward the top.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      code <= above;
    end else if (cmd.pop) begin
      code <= below;
    end
  end

endmodule

[rtl/i2p_ctrl.sv]
// Sequencer: classifies each character, drives pops and pushes on the cell
// row and holds the output beat register. Depends on i2p_pkg.
module i2p_ctrl
  import i2p_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tuser,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  input  logic [2:0] top_code,
  input  logic [2:0] second_code,
  output stack_cmd_t cmd
);

  typedef enum logic { ST_IDLE, ST_BUSY } state_t;

  typedef enum logic [2:0] {
    CL_FLUSH, CL_OPERAND, CL_OPEN, CL_CLOSE, CL_OPER, CL_IGNORE
  } class_t;

  state_t              state;
  class_t              cls;
  logic [7:0]          sym;
  logic [2:0]          opc;
  logic [CNT_W-1:0]    count;
  logic [EMIT_W-1:0]   n;

  logic slot_free;
  logic top_pops;
  logic next_pops;
  logic full;
  logic empty;
  logic beat_load;

  function automatic logic [2:0] char_code(input logic [7:0] ch);
    case (ch)
      CH_ADD:  char_code = OP_ADD;
      CH_SUB:  char_code = OP_SUB;
      CH_MUL:  char_code = OP_MUL;
      CH_DIV:  char_code = OP_DIV;
      CH_MOD:  char_code = OP_MOD;
      CH_POW:  char_code = OP_POW;
      default: char_code = OP_OPEN;
    endcase
  endfunction

  function automatic class_t classify(input logic k, input logic [7:0] ch);
    if (k) begin
      classify = CL_FLUSH;
    end else if ((ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
                 (ch >= 8'h61 && ch <= 8'h7A)) begin
      classify = CL_OPERAND;
    end else if (ch == CH_OPEN) begin
      classify = CL_OPEN;
    end else if (ch == CH_CLOSE) begin
      classify = CL_CLOSE;
    end else if (char_code(ch) != OP_OPEN) begin
      classify = CL_OPER;
    end else begin
      classify = CL_IGNORE;
    end
  endfunction

  // Whether an entry on top of the stack is popped by the item in hand.
  function automatic logic pop_rule(input class_t c, input logic [2:0] t,
                                    input logic [2:0] inc);
    logic [1:0] tp;
    logic [1:0] ip;
    tp = op_prec(t);
    ip = op_prec(inc);
    case (c)
      CL_FLUSH: pop_rule = 1'b1;
      CL_CLOSE: pop_rule = (t != OP_OPEN);
      CL_OPER:  pop_rule = (t != OP_OPEN) &&
                           ((tp > ip) || ((tp == ip) && (inc != OP_POW)));
      default:  pop_rule = 1'b0;
    endcase
  endfunction

  assign s_tready  = (state == ST_IDLE);
  assign slot_free = !m_tvalid || m_tready;
  assign full      = (count == CNT_W'(STACK_DEPTH));
  assign empty     = (count == '0);
  assign top_pops  = pop_rule(cls, top_code, opc) && !empty &&
                     (n != EMIT_W'(MAX_RESULTS));
  // The pop after this one, judged on the entry below the top.
  assign next_pops = pop_rule(cls, second_code, opc) && (count > CNT_W'(1)) &&
                     (n != EMIT_W'(MAX_RESULTS - 1));
  assign beat_load = (state == ST_BUSY) && slot_free &&
                     (top_pops || (cls == CL_OPERAND));

  always_comb begin
    cmd.push = 1'b0;
    cmd.pop  = 1'b0;
    cmd.code = opc;
    if (state == ST_BUSY) begin
      if (top_pops) begin
        cmd.pop = slot_free;
      end else begin
        case (cls)
          CL_OPEN: begin
            cmd.push = !full;
            cmd.code = OP_OPEN;
          end
          CL_OPER:  cmd.push = !full;
          CL_CLOSE: cmd.pop  = !empty && (top_code == OP_OPEN);
          default:  cmd.pop  = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      n        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (beat_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.push) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop) begin
        count <= count - CNT_W'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cls   <= classify(s_tuser, s_tdata);
            sym   <= s_tdata;
            opc   <= char_code(s_tdata);
            n     <= '0;
            state <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (top_pops) begin
            if (slot_free) begin
              m_tdata  <= op_char(top_code);
              m_tlast  <= !next_pops;
              n        <= n + EMIT_W'(1);
            end
          end else if (cls == CL_OPERAND) begin
            if (slot_free) begin
              m_tdata  <= sym;
              m_tlast  <= 1'b1;
              state    <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/infix_to_postfix_converter_top.sv]
// Channel  | dir | tdata          | tuser     | tlast
// s_*      | in  | [7:0] symbol_in | kind     | -
// m_*      | out | [7:0] symbol_out| -        | last
//
// Items are taken only while idle; for each, the sequencer emits one symbol
// per pop, then pushes, emits or drops the item, with a single pop per
// cycle on the cell row. Output beats sit in one register; a stall there holds
// the sequencer. Synchronous reset empties the stack at once; no clearing pass.
// Depends on i2p_pkg, i2p_cell, i2p_ctrl.
module infix_to_postfix_converter_top
  import i2p_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol_in
  input  logic       s_tuser,   // [0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] symbol_out
  output logic       m_tlast
);

  stack_cmd_t cmd;
  logic [2:0] cell_code [STACK_DEPTH];

  i2p_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .top_code    (cell_code[0]),
    .second_code (cell_code[1]),
    .cmd         (cmd)
  );

  // Cell 0 is the top of the stack.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [2:0] above;
    logic [2:0] below;
    if (i == 0) begin : g_first
      assign above = cmd.code;
    end else begin : g_mid
      assign above = cell_code[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = cell_code[i];
    end else begin : g_inner
      assign below = cell_code[i+1];
    end
    i2p_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .above (above),
      .below (below),
      .code  (cell_code[i])
    );
  end

endmodule

[rtl/i2p_checker.sv]
// Port-level checker for the converter, bound to the top level.
// Depends on assert_macros.svh and i2p_pkg.
`include "assert_macros.svh"

module i2p_checker
  import i2p_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  logic sym_ok;

  assign sym_ok = (m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
                  (m_tdata >= 8'h41 && m_tdata <= 8'h5A) ||
                  (m_tdata >= 8'h61 && m_tdata <= 8'h7A) ||
                  (m_tdata == CH_ADD) || (m_tdata == CH_SUB) || (m_tdata == CH_MUL) ||
                  (m_tdata == CH_DIV) || (m_tdata == CH_MOD) || (m_tdata == CH_POW) ||
                  (m_tdata == CH_OPEN);

  `CHK_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
            m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  `CHK_NEXT(a_busy_after_beat, clk, rst, s_tvalid && s_tready, !s_tready)
  `CHK_NEXT(a_quiet_after_reset, clk, 1'b0, rst, !m_tvalid)
  `CHK_HOLD(a_symbol_legal, clk, rst, !m_tvalid || sym_ok)

endmodule

bind infix_to_postfix_converter_top i2p_checker u_i2p_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
